>>> design/homogeneous_point_transform_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the homogeneous point transform
// Concurrent check macros; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef HOMOGENEOUS_POINT_TRANSFORM_ASSERT_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_ASSERT_SVH
`ifndef ASSERT_OFF
`define HPT_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("hpt assertion failed");
`define HPT_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("hpt assertion failed");
`else
`define HPT_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define HPT_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

>>> design/hpt_pkg.sv
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared types and constants of the homogeneous point transform.
// ----------------------------------------------------------------------------
package hpt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NDIV      = 32;            // quotient bits, one per stage
    localparam int NSTG      = 2 + NDIV + 2;  // mult, sum, prep, steps, final
    localparam int NREG      = 8;
    localparam int IDX_W     = 4;
    localparam int CFG_W     = 64;

    // register indexes
    localparam logic [IDX_W-1:0] REG_ROW0_FIRST  = 4'd0;
    localparam logic [IDX_W-1:0] REG_ROW0_SECOND = 4'd1;
    localparam logic [IDX_W-1:0] REG_ROW1_FIRST  = 4'd2;
    localparam logic [IDX_W-1:0] REG_ROW1_SECOND = 4'd3;
    localparam logic [IDX_W-1:0] REG_ROW2_FIRST  = 4'd4;
    localparam logic [IDX_W-1:0] REG_ROW2_SECOND = 4'd5;
    localparam logic [IDX_W-1:0] REG_ROW3_FIRST  = 4'd6;
    localparam logic [IDX_W-1:0] REG_ROW3_SECOND = 4'd7;

    localparam logic [CFG_W-1:0] ONE_LO = CFG_W'(64'd1 << FRAC_BITS);
    localparam logic [CFG_W-1:0] ONE_HI = CFG_W'(64'd1 << (FRAC_BITS + 32));

    // [row][col] coefficients, two's complement
    typedef logic [3:0][3:0][31:0] coef_mat_t;

    typedef struct packed {
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               w_was_zero;
        logic               saturated;
    } out_word_t;

    // flags that ride along the divide stages
    typedef struct packed {
        logic w_zero;
        logic row_sat;
    } flag_t;

endpackage

>>> design/hpt_if.sv
// ----------------------------------------------------------------------------
// hpt_in_if / hpt_out_if
// Valid/ready channels carrying point words and result words.
// ----------------------------------------------------------------------------
interface hpt_in_if;
    logic              valid;
    logic              ready;
    hpt_pkg::in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hpt_out_if;
    logic               valid;
    logic               ready;
    hpt_pkg::out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/hpt_row_sum.sv
// ----------------------------------------------------------------------------
// hpt_row_sum
// Two stages: twelve registered products, then floor shift, row sums, clamp.
// ----------------------------------------------------------------------------
module hpt_row_sum
(
    input  logic                clk,
    input  logic [1:0]          ld,
    input  hpt_pkg::in_word_t   pt,
    input  hpt_pkg::coef_mat_t  coef,
    output logic signed [31:0]  r [4],
    output logic                sat
);

    localparam int SW = 66;
    localparam logic signed [SW-1:0] MAXV = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0] MINV = -SW'(66'sd2147483648);

    logic signed [63:0] prod_reg [4][3];
    logic signed [31:0] c3_reg   [4];
    logic signed [31:0] r_reg    [4];
    logic signed [31:0] r_next   [4];
    logic               sat_reg;
    logic               sat_next;
    logic signed [31:0] p_in     [3];

    assign p_in[0] = pt.in_x;
    assign p_in[1] = pt.in_y;
    assign p_in[2] = pt.in_z;

    // stage 1: products
    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            for (int i = 0; i < 4; i++)
            begin
                for (int k = 0; k < 3; k++)
                    prod_reg[i][k] <= p_in[k] * $signed(coef[i][k]);
                c3_reg[i] <= $signed(coef[i][3]);
            end
        end
    end

    // stage 2: floor shift, sum, clamp
    always_comb
    begin
        logic signed [SW-1:0] s;
        sat_next = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            s = SW'(c3_reg[i]);
            for (int k = 0; k < 3; k++)
                s = s + SW'(prod_reg[i][k] >>> hpt_pkg::FRAC_BITS);
            if (s > MAXV)
            begin
                r_next[i] = 32'sh7FFFFFFF;
                sat_next  = 1'b1;
            end
            else if (s < MINV)
            begin
                r_next[i] = 32'sh80000000;
                sat_next  = 1'b1;
            end
            else
            begin
                r_next[i] = s[31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            r_reg   <= r_next;
            sat_reg <= sat_next;
        end
    end

    assign r   = r_reg;
    assign sat = sat_reg;

endmodule

>>> design/hpt_div_lane.sv
// ----------------------------------------------------------------------------
// hpt_div_lane
// Pipelined restoring divide of (r << FRAC_BITS) by w, one quotient bit per
// stage, with magnitude prep, sign fix and clamp to 32 bits.
// ----------------------------------------------------------------------------
module hpt_div_lane
(
    input  logic                        clk,
    input  logic [hpt_pkg::NDIV+1:0]    ld,
    input  logic signed [31:0]          r,
    input  logic signed [31:0]          w,
    output logic signed [31:0]          q,
    output logic                        qsat
);

    localparam int ND = hpt_pkg::NDIV;
    localparam int F  = hpt_pkg::FRAC_BITS;

    logic [31:0] rem_reg [0:ND];
    logic [31:0] nlo_reg [0:ND];
    logic [31:0] quo_reg [0:ND];
    logic [31:0] den_reg [0:ND];
    logic        neg_reg [0:ND];
    logic        ovf_reg [0:ND];

    logic [31:0] mag_r;
    logic [31:0] mag_w;
    logic [63:0] num;
    logic [31:0] num_hi;

    // prep: magnitudes, early overflow test (quotient >= 2^32)
    assign mag_r  = r[31] ? 32'(-r) : 32'(r);
    assign mag_w  = w[31] ? 32'(-w) : 32'(w);
    assign num    = {32'd0, mag_r} << F;
    assign num_hi = num[63:32];

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            rem_reg[0] <= num_hi;
            nlo_reg[0] <= num[31:0];
            quo_reg[0] <= '0;
            den_reg[0] <= mag_w;
            neg_reg[0] <= r[31] ^ w[31];
            ovf_reg[0] <= (num_hi >= mag_w);
        end
    end

    // one quotient bit per stage
    for (genvar j = 1; j <= ND; j++)
    begin : g_step
        logic [32:0] t;
        logic        take;
        assign t    = {rem_reg[j-1], nlo_reg[j-1][31]};
        assign take = (t >= {1'b0, den_reg[j-1]});

        always_ff @(posedge clk)
        begin
            if (ld[j])
            begin
                rem_reg[j] <= take ? 32'(t - {1'b0, den_reg[j-1]}) : t[31:0];
                nlo_reg[j] <= {nlo_reg[j-1][30:0], 1'b0};
                quo_reg[j] <= {quo_reg[j-1][30:0], take};
                den_reg[j] <= den_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
            end
        end
    end

    // sign fix and clamp
    logic signed [31:0] q_reg, q_next;
    logic               qsat_reg, qsat_next;
    logic [31:0]        qu;

    assign qu = quo_reg[ND];

    always_comb
    begin
        qsat_next = 1'b0;
        if (ovf_reg[ND])
        begin
            qsat_next = 1'b1;
            q_next    = neg_reg[ND] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        else if (neg_reg[ND])
        begin
            if (qu > 32'h80000000)
            begin
                qsat_next = 1'b1;
                q_next    = 32'sh80000000;
            end
            else
            begin
                q_next = 32'(-qu);
            end
        end
        else
        begin
            if (qu[31])
            begin
                qsat_next = 1'b1;
                q_next    = 32'sh7FFFFFFF;
            end
            else
            begin
                q_next = qu;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[ND+1])
        begin
            q_reg    <= q_next;
            qsat_reg <= qsat_next;
        end
    end

    assign q    = q_reg;
    assign qsat = qsat_reg;

endmodule

>>> design/homogeneous_point_transform.sv
// ----------------------------------------------------------------------------
// homogeneous_point_transform
// 4x4 homogeneous transform of a Q16.16 point with perspective divide.
// ----------------------------------------------------------------------------
// One point word enters per cycle unless backpressure stalls the pipe:
// two stages for the products and row sums, one divide prep stage, 32 stages
// of the bit-per-stage divider (one quotient bit each) and a final sign and
// clamp stage. Every stage holds its word under backpressure; input ready
// stays high while any stage has room. The user must write the matrix through
// cfg_we/cfg_index/cfg_data while the pipe is empty (block does not enforce).
module homogeneous_point_transform
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [hpt_pkg::IDX_W-1:0]   cfg_index,
    input  logic [hpt_pkg::CFG_W-1:0]   cfg_data,
    hpt_in_if.sink                      pt_in,
    hpt_out_if.source                   pt_out
);

    localparam int NS = hpt_pkg::NSTG;
    localparam int ND = hpt_pkg::NDIV;

    // configuration registers
    logic [hpt_pkg::CFG_W-1:0] cfg_reg [hpt_pkg::NREG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[0] <= hpt_pkg::ONE_LO;
            cfg_reg[1] <= '0;
            cfg_reg[2] <= hpt_pkg::ONE_HI;
            cfg_reg[3] <= '0;
            cfg_reg[4] <= '0;
            cfg_reg[5] <= hpt_pkg::ONE_LO;
            cfg_reg[6] <= '0;
            cfg_reg[7] <= hpt_pkg::ONE_HI;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hpt_pkg::REG_ROW0_FIRST:  cfg_reg[0] <= cfg_data;
                hpt_pkg::REG_ROW0_SECOND: cfg_reg[1] <= cfg_data;
                hpt_pkg::REG_ROW1_FIRST:  cfg_reg[2] <= cfg_data;
                hpt_pkg::REG_ROW1_SECOND: cfg_reg[3] <= cfg_data;
                hpt_pkg::REG_ROW2_FIRST:  cfg_reg[4] <= cfg_data;
                hpt_pkg::REG_ROW2_SECOND: cfg_reg[5] <= cfg_data;
                hpt_pkg::REG_ROW3_FIRST:  cfg_reg[6] <= cfg_data;
                hpt_pkg::REG_ROW3_SECOND: cfg_reg[7] <= cfg_data;
                default: ;
            endcase
        end
    end

    hpt_pkg::coef_mat_t coef;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            coef[i][0] = cfg_reg[2*i][31:0];
            coef[i][1] = cfg_reg[2*i][63:32];
            coef[i][2] = cfg_reg[2*i+1][31:0];
            coef[i][3] = cfg_reg[2*i+1][63:32];
        end
    end

    // stage valids and load chain
    logic [NS-1:0] v_reg;
    logic [NS-1:0] ld;

    always_comb
    begin
        ld[NS-1] = !v_reg[NS-1] || pt_out.ready;
        for (int k = NS - 2; k >= 0; k--)
            ld[k] = !v_reg[k] || ld[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ld[0])
                v_reg[0] <= pt_in.valid;
            for (int k = 1; k < NS; k++)
            begin
                if (ld[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    assign pt_in.ready = ld[0];

    // products and row sums
    logic signed [31:0] r [4];
    logic               row_sat;

    hpt_row_sum u_row_sum
    (
        .clk  (clk),
        .ld   (ld[1:0]),
        .pt   (pt_in.data),
        .coef (coef),
        .r    (r),
        .sat  (row_sat)
    );

    // flags follow the divide stages
    hpt_pkg::flag_t flag_reg [2:NS-1];

    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            flag_reg[2].w_zero  <= (r[3] == 32'sd0);
            flag_reg[2].row_sat <= row_sat;
        end
        for (int k = 3; k < NS; k++)
        begin
            if (ld[k])
                flag_reg[k] <= flag_reg[k-1];
        end
    end

    // three divide lanes
    logic signed [31:0] q    [3];
    logic               qsat [3];

    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        hpt_div_lane u_div_lane
        (
            .clk  (clk),
            .ld   (ld[ND+3:2]),
            .r    (r[l]),
            .w    (r[3]),
            .q    (q[l]),
            .qsat (qsat[l])
        );
    end

    // result word
    logic wz;
    assign wz = flag_reg[NS-1].w_zero;

    assign pt_out.valid           = v_reg[NS-1];
    assign pt_out.data.out_x      = wz ? 32'sd0 : q[0];
    assign pt_out.data.out_y      = wz ? 32'sd0 : q[1];
    assign pt_out.data.out_z      = wz ? 32'sd0 : q[2];
    assign pt_out.data.w_was_zero = wz;
    assign pt_out.data.saturated  = flag_reg[NS-1].row_sat ||
                                    (!wz && (qsat[0] || qsat[1] || qsat[2]));

`include "homogeneous_point_transform_assert.svh"

    // zero w forces a zero point
    `HPT_ASSERT_IMPLIES(a_wz_zero, clk, rst_n, pt_out.valid && pt_out.data.w_was_zero, (pt_out.data.out_x == 0) && (pt_out.data.out_y == 0) && (pt_out.data.out_z == 0))
    // an empty last stage lets the whole chain load
    `HPT_ASSERT_IMPLIES(a_room, clk, rst_n, !v_reg[NS-1], pt_in.ready)
    // a word taken at the input shows up in the first stage
    `HPT_ASSERT_NEXT(a_enter, clk, rst_n, pt_in.valid && pt_in.ready, v_reg[0])

endmodule
